/* design/atp_pkg.sv */
// Shared types, character codes and event codes for the AT response parser.
`timescale 1ns / 1ps

package atp_pkg;

	localparam int unsigned CountW = 7;
	localparam logic [3:0] CLOSED_LEN = 4'd10;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PROMPT  = 8'h3E;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;

	localparam logic [15:0] TIMEOUT_DEFAULT = 16'd60000;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_LINE    = 2'd1;
	localparam logic [1:0] EV_PAYLOAD = 2'd2;
	localparam logic [1:0] EV_PROMPT  = 2'd3;

	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_CLEAR = 2'd1;
	localparam logic [1:0] TMR_LOAD  = 2'd2;

	typedef enum logic [2:0] {
		MODE_LINE   = 3'b001,
		MODE_IPD    = 3'b010,
		MODE_PROMPT = 3'b100
	} rx_mode_t;

	typedef struct packed {
		rx_mode_t          mode;
		logic              ipd_phase;
		logic [CountW-1:0] count;
		logic [7:0]        length_accum;
		logic [7:0]        remaining;
		logic              close_ok;
	} parse_state_t;

	typedef struct packed {
		logic [7:0]        echo_byte;
		logic [CountW-1:0] store_index;
		logic [1:0]        event_res;
		logic              closed_line;
		logic [CountW-1:0] message_length;
		logic [1:0]        timer_action;
	} parse_result_t;

	// Characters of the closed-connection line "0,CLOSED\r\n"
	function automatic logic [7:0] closed_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h30;
			4'd1:    c = 8'h2C;
			4'd2:    c = 8'h43;
			4'd3:    c = 8'h4C;
			4'd4:    c = 8'h4F;
			4'd5:    c = 8'h53;
			4'd6:    c = 8'h45;
			4'd7:    c = 8'h44;
			4'd8:    c = 8'h0D;
			4'd9:    c = 8'h0A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/atp_step.sv */
// Per-byte classification logic: next parser state and the result for one byte.
`timescale 1ns / 1ps

module atp_step #(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  logic [7:0]            rx_byte,
	input  atp_pkg::parse_state_t cur,
	output atp_pkg::parse_state_t nxt,
	output atp_pkg::parse_result_t res
);
	import atp_pkg::*;

	logic [CountW-1:0] p;
	logic [CountW:0]   inc;
	logic [CountW-1:0] next_idx;
	logic              ok;
	logic              entering;
	rx_mode_t          mode_eff;
	logic              phase_eff;
	logic [7:0]        rem_dec;
	logic [7:0]        acc_mul;

	assign p        = cur.count;
	assign inc      = {1'b0, p} + {{CountW{1'b0}}, 1'b1};
	assign next_idx = (inc >= (CountW+1)'(BUFFER_DEPTH)) ? '0 : inc[CountW-1:0];
	assign rem_dec  = cur.remaining - 8'd1;
	assign acc_mul  = {cur.length_accum[4:0], 3'b000} + {cur.length_accum[6:0], 1'b0};

	always_comb begin
		ok = (p == '0) ? 1'b1 : cur.close_ok;
		ok = ok && (p < CountW'(CLOSED_LEN)) && (rx_byte == closed_char(p[3:0]));
	end

	always_comb begin
		entering  = 1'b0;
		mode_eff  = cur.mode;
		phase_eff = cur.ipd_phase;
		if (cur.mode == MODE_LINE && p == '0 && rx_byte == CH_PLUS) begin
			entering  = 1'b1;
			mode_eff  = MODE_IPD;
			phase_eff = 1'b0;
		end else if (cur.mode == MODE_LINE && p == '0 && rx_byte == CH_PROMPT) begin
			mode_eff = MODE_PROMPT;
		end
	end

	always_comb begin
		nxt              = cur;
		nxt.mode         = mode_eff;
		nxt.ipd_phase    = phase_eff;
		nxt.close_ok     = ok;
		nxt.count        = next_idx;
		if (entering)
			nxt.length_accum = '0;

		res.echo_byte      = rx_byte;
		res.store_index    = p;
		res.event_res      = EV_NONE;
		res.closed_line    = 1'b0;
		res.message_length = '0;
		res.timer_action   = TMR_NONE;

		unique case (mode_eff)
			MODE_LINE: begin
				if (rx_byte == CH_NEWLINE) begin
					res.event_res      = EV_LINE;
					res.message_length = next_idx;
					if (ok && p == CountW'(CLOSED_LEN - 4'd1)) begin
						res.closed_line  = 1'b1;
						res.timer_action = TMR_CLEAR;
					end
					nxt.count    = '0;
					nxt.close_ok = 1'b1;
				end
			end
			MODE_IPD: begin
				if (!phase_eff) begin
					priority if (rx_byte == CH_COLON) begin
						nxt.remaining = cur.length_accum;
						nxt.count     = '0;
						nxt.close_ok  = 1'b1;
						nxt.ipd_phase = 1'b1;
					end else if (rx_byte == CH_COMMA) begin
						nxt.length_accum = '0;
					end else if (rx_byte != CH_PLUS || p != '0) begin
						nxt.length_accum = acc_mul + rx_byte - CH_ZERO;
					end
				end else begin
					nxt.remaining = rem_dec;
					if (rem_dec == 8'd0) begin
						res.event_res      = EV_PAYLOAD;
						res.message_length = next_idx;
						res.timer_action   = TMR_LOAD;
						nxt.ipd_phase      = 1'b0;
						nxt.mode           = MODE_LINE;
						nxt.count          = '0;
						nxt.close_ok       = 1'b1;
					end
				end
			end
			default: begin
				// prompt: report and fall back to line mode
				res.event_res      = EV_PROMPT;
				res.message_length = next_idx;
				nxt.mode           = MODE_LINE;
				nxt.count          = '0;
				nxt.close_ok       = 1'b1;
			end
		endcase
	end

endmodule

/* design/at_response_stream_parser.sv */
// Top level of the AT response stream parser: beat registers, parser state, config.
`timescale 1ns / 1ps

// AT response stream parser.
// Input channel: in_valid / in_ready carry one received character (rx_byte)
// per beat. Output channel: out_valid / out_ready carry one result per input
// beat: the echoed byte, its buffer index, the event code, the closed-line
// flag, the message length and the timer action.
// Configuration: cfg_valid / cfg_ready write timeout_reload (cfg_data); the
// port is always ready and must be written only while the block is idle (the
// block itself does not enforce this). The current reload value stands on
// timeout_reload for the connection timer. An accepted beat goes into the
// input register, then through one pass of the classification logic into
// the result register, which drives out_valid.
// Throughput: one byte per cycle while the receiver keeps out_ready high;
// back-to-back beats are then taken without gaps.
// Reset (arst_n low): line mode, store index zero, closed-line match armed,
// timeout_reload back to 60000, both beat registers empty.
// Receiver stall: the result register holds its beat, the input register keeps
// the next byte, and in_ready drops once both are full.

module at_response_stream_parser #(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  echo_byte,
	output logic [6:0]  store_index,
	output logic [1:0]  event_res,
	output logic        closed_line,
	output logic [6:0]  message_length,
	output logic [1:0]  timer_action,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic [15:0] timeout_reload
);
	import atp_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	parse_state_t  state_q;
	parse_state_t  state_next;
	parse_result_t res_comb;
	parse_result_t res_s2;
	logic          valid_s2;
	logic [15:0]   timeout_reload_q;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	atp_step #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_step (
		.rx_byte(byte_s1),
		.cur    (state_q),
		.nxt    (state_next),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_LINE;
			state_q.ipd_phase    <= 1'b0;
			state_q.count        <= '0;
			state_q.length_accum <= '0;
			state_q.remaining    <= '0;
			state_q.close_ok     <= 1'b1;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// hold the result beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	// reload value for the connection timer, taken when a frame ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_reload_q <= TIMEOUT_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			timeout_reload_q <= cfg_data;
		end
	end

	assign out_valid      = valid_s2;
	assign echo_byte      = res_s2.echo_byte;
	assign store_index    = res_s2.store_index;
	assign event_res      = res_s2.event_res;
	assign closed_line    = res_s2.closed_line;
	assign message_length = res_s2.message_length;
	assign timer_action   = res_s2.timer_action;
	assign timeout_reload = timeout_reload_q;

endmodule
